@@ src/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// Software timer table package
// Shared constants, codes and types for the software timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int NUM_ENTRIES = 8;
    localparam int RESULT_CAP  = 8;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
    localparam int EV_W        = $clog2(RESULT_CAP + 1);

    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int TICK_W   = 16;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 2;

    // consumer_id, periodic, period_time packed from bit 0, padded to bytes
    localparam int S_FIELD_W = ID_W + 1 + TIME_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    // status, fired_id packed from bit 0, padded to bytes
    localparam int M_FIELD_W = STATUS_W + ID_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_INIT  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam logic REG_ENABLED   = 1'b0;
    localparam logic REG_TICK_TIME = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SWEEP,
        S_FLUSH
    } stt_state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] count;
        logic              periodic;
    } entry_t;

endpackage

@@ src/software_timer_table.sv @@
// ----------------------------------------------------------------------------
// Software timer table
// Table of consumer timers driven by start, stop and base tick transactions.
// ----------------------------------------------------------------------------
// Start and stop search the filled entries through the table memory read
// port, one entry per cycle; the flush state then hands the status to the
// output register once it is free. A dispatch tick sweeps every entry, one
// per cycle while the output does not stall. A start on a full table reuses
// the first inactive entry without a search. One item is in work at a time;
// a result waiting in the output register does not block input.
// Reset clears control, active bits and counters; the table memory is not
// cleared, as entries are qualified by the fill count and the active bits.
module software_timer_table (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] consumer_id, [16] periodic, [48:17] period_time
    input  logic [stt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [stt_pkg::OP_W-1:0]       s_axis_tuser,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [2:0] status, [18:3] fired_id
    output logic [stt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [0] kind
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [stt_pkg::TICK_W-1:0]     cfg_data
);
    import stt_pkg::*;

    // configuration
    logic              enabled_reg;
    logic [TICK_W-1:0] tick_time_reg;

    // control
    stt_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [TICK_W-1:0] base_reg, base_next;
    logic [EV_W-1:0]   n_reg, n_next;
    logic [NUM_ENTRIES-1:0] active_reg, active_next;

    // captured item
    logic              op_reg;          // 1: stop, 0: start (only used in scan)
    logic [ID_W-1:0]   id_reg;
    logic              pd_reg;
    logic [TIME_W-1:0] per_reg;
    logic              capture;

    // one-deep pending result, held until we know whether it is the last
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_kind_reg, pend_kind_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [ID_W-1:0]     pend_id_reg, pend_id_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic                out_last_reg, out_last_next;
    logic                out_free;

    // table memory
    entry_t           mem [NUM_ENTRIES];
    entry_t           rdata_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;

    // input fields
    logic [OP_W-1:0]   in_op;
    logic [ID_W-1:0]   in_id;
    logic              in_pd;
    logic [TIME_W-1:0] in_per;

    // helpers
    logic              free_hit;
    logic [IDX_W-1:0]  free_idx;
    logic [TICK_W-1:0] base_inc;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] new_count;
    logic              fire;
    logic              stall;
    logic              id_match;
    logic              scan_last;
    logic              sweep_last;
    logic [NUM_ENTRIES-1:0] filled_mask;

    assign in_op  = s_axis_tuser;
    assign in_id  = s_axis_tdata[ID_W-1:0];
    assign in_pd  = s_axis_tdata[ID_W];
    assign in_per = s_axis_tdata[ID_W+1 +: TIME_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-M_FIELD_W){1'b0}}, out_id_reg, out_status_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= 1'b0;
            tick_time_reg <= TICK_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ENABLED:   enabled_reg   <= cfg_data[0];
                REG_TICK_TIME: tick_time_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // table memory: one write port, one registered read port
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // first inactive entry, used when the table is full
    always_comb begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_hit = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            filled_mask[i] = (CNT_W'(i) < fill_reg);
        end
    end

    assign base_inc   = base_reg + TICK_W'(1);
    assign sum        = {1'b0, rdata_reg.count} + (TIME_W + 1)'(tick_time_reg);
    assign new_count  = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    assign fire       = active_reg[idx_reg] && (new_count >= rdata_reg.period)
                        && (n_reg < EV_W'(RESULT_CAP));
    assign stall      = fire && pend_valid_reg && !out_free;
    assign id_match   = (rdata_reg.id == id_reg);
    assign scan_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg);
    assign sweep_last = (idx_reg == IDX_W'(NUM_ENTRIES - 1));

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            fill_reg       <= '0;
            base_reg       <= '0;
            n_reg          <= '0;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            fill_reg       <= fill_next;
            base_reg       <= base_next;
            n_reg          <= n_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (capture) begin
            op_reg  <= (in_op == OP_STOP);
            id_reg  <= in_id;
            pd_reg  <= in_pd;
            per_reg <= in_per;
        end
        pend_kind_reg   <= pend_kind_next;
        pend_status_reg <= pend_status_next;
        pend_id_reg     <= pend_id_next;
        out_kind_reg    <= out_kind_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_last_reg    <= out_last_next;
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        fill_next        = fill_reg;
        base_next        = base_reg;
        n_next           = n_reg;
        active_next      = active_reg;
        pend_valid_next  = pend_valid_reg;
        pend_kind_next   = pend_kind_reg;
        pend_status_next = pend_status_reg;
        pend_id_next     = pend_id_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_kind_next    = out_kind_reg;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_last_next    = out_last_reg;
        capture          = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = idx_reg;
        wr_data          = rdata_reg;
        rd_addr          = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    capture = 1'b1;
                    idx_next = '0;
                    case (in_op)
                        OP_START: begin
                            pend_kind_next = KIND_STATUS;
                            pend_id_next   = '0;
                            if (!enabled_reg) begin
                                pend_valid_next  = 1'b1;
                                pend_status_next = STAT_NOT_INIT;
                                state_next       = S_FLUSH;
                            end else if (fill_reg >= CNT_W'(NUM_ENTRIES)) begin
                                // full: reuse first inactive entry, no ID check
                                pend_valid_next = 1'b1;
                                state_next      = S_FLUSH;
                                if (free_hit) begin
                                    wr_en            = 1'b1;
                                    wr_addr          = free_idx;
                                    wr_data          = '{in_id, in_per, '0, in_pd};
                                    active_next[free_idx] = 1'b1;
                                    pend_status_next = STAT_OK;
                                end else begin
                                    pend_status_next = STAT_FULL;
                                end
                            end else if (fill_reg == '0) begin
                                wr_en            = 1'b1;
                                wr_addr          = '0;
                                wr_data          = '{in_id, in_per, '0, in_pd};
                                active_next[0]   = 1'b1;
                                fill_next        = CNT_W'(1);
                                pend_valid_next  = 1'b1;
                                pend_status_next = STAT_OK;
                                state_next       = S_FLUSH;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_STOP: begin
                            pend_kind_next = KIND_STATUS;
                            pend_id_next   = '0;
                            if (fill_reg == '0) begin
                                pend_valid_next  = 1'b1;
                                pend_status_next = STAT_NOT_FOUND;
                                state_next       = S_FLUSH;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_TICK: begin
                            if (enabled_reg) begin
                                if (base_inc >= tick_time_reg) begin
                                    base_next  = '0;
                                    n_next     = '0;
                                    state_next = S_SWEEP;
                                end else begin
                                    base_next = base_inc;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN: begin
                if (id_match) begin
                    pend_valid_next = 1'b1;
                    state_next      = S_FLUSH;
                    if (op_reg) begin
                        active_next[idx_reg] = 1'b0;
                        pend_status_next     = STAT_OK;
                    end else begin
                        pend_status_next = STAT_DUPLICATE;
                    end
                end else if (scan_last) begin
                    pend_valid_next = 1'b1;
                    state_next      = S_FLUSH;
                    if (op_reg) begin
                        pend_status_next = STAT_NOT_FOUND;
                    end else begin
                        // append behind the filled entries
                        wr_en            = 1'b1;
                        wr_addr          = fill_reg[IDX_W-1:0];
                        wr_data          = '{id_reg, per_reg, '0, pd_reg};
                        active_next[fill_reg[IDX_W-1:0]] = 1'b1;
                        fill_next        = fill_reg + CNT_W'(1);
                        pend_status_next = STAT_OK;
                    end
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                    rd_addr  = idx_reg + IDX_W'(1);
                end
            end

            S_SWEEP: begin
                if (stall) begin
                    // hold: re-read the same entry
                    rd_addr = idx_reg;
                end else begin
                    rd_addr       = sweep_last ? '0 : idx_reg + IDX_W'(1);
                    wr_en         = 1'b1;
                    wr_addr       = idx_reg;
                    wr_data.count = (fire && rdata_reg.periodic) ? '0 : new_count;
                    if (fire) begin
                        if (!rdata_reg.periodic) begin
                            active_next[idx_reg] = 1'b0;
                        end
                        n_next = n_reg + EV_W'(1);
                        if (pend_valid_reg) begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = pend_kind_reg;
                            out_status_next = pend_status_reg;
                            out_id_next     = pend_id_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_kind_next   = KIND_EXPIRY;
                        pend_status_next = STAT_OK;
                        pend_id_next     = rdata_reg.id;
                    end
                    if (sweep_last) begin
                        state_next = S_FLUSH;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            S_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_status_next = pend_status_reg;
                    out_id_next     = pend_id_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(NUM_ENTRIES))
        else $error("fill count beyond table depth");

    a_active_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg & ~filled_mask) == '0)
        else $error("active entry outside the filled range");

    a_event_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= EV_W'(RESULT_CAP))
        else $error("too many expiry events for one tick");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending result left behind in idle");

    a_expiry_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == KIND_EXPIRY) |-> out_status_reg == STAT_OK)
        else $error("expiry event with nonzero status");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP && stall) |=> state_reg == S_SWEEP && $stable(idx_reg))
        else $error("sweep advanced while the event path was stalled");

endmodule
